/* rtl/core/rpc_pkg.sv */
`default_nettype none

package rpc_pkg;

    localparam int unsigned OFFSET_W = 23;
    localparam int unsigned LENGTH_W = 24;
    localparam int unsigned POS_W    = 24;
    localparam int unsigned END_W    = 25;
    localparam int unsigned CRC_W    = 32;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned INDEX_W  = 3;

    localparam logic [POS_W-1:0] MAX_REGION_BYTES = 24'd8388608;
    localparam logic [CRC_W-1:0] CRC_INIT         = 32'hffffffff;
    localparam logic [CRC_W-1:0] CRC_POLY         = 32'h82f63b78;

    typedef enum logic [INDEX_W-1:0] {
        REG_PAYLOAD_OFFSET       = 3'd0,
        REG_PAYLOAD_LENGTH       = 3'd1,
        REG_FILL_VALUE           = 3'd2,
        REG_CHECK_SENTINELS      = 3'd3,
        REG_PATTERN_SEED         = 3'd4,
        REG_PATTERN_MULTIPLIER   = 3'd5,
        REG_PATTERN_QUARTER_STEP = 3'd6,
        REG_CRC_EXPECTED         = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] payload_offset;
        logic [LENGTH_W-1:0] payload_length;
        logic [7:0]          fill_value;
        logic                check_sentinels;
        logic [7:0]          pattern_seed;
        logic [7:0]          pattern_multiplier;
        logic [7:0]          pattern_quarter_step;
        logic [CRC_W-1:0]    crc_expected;
    } cfg_t;

    function automatic logic [CRC_W-1:0] crc32c_byte(
        input logic [CRC_W-1:0] crc_in,
        input logic [7:0]       data_in
    );
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {24'd0, data_in};
        for (int k = 0; k < 8; k++)
        begin
            crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : '0);
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/rpc_cfg_regs.sv */
`default_nettype none

module rpc_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [rpc_pkg::INDEX_W-1:0]   cfg_index,
    input  wire logic [rpc_pkg::CFG_W-1:0]     cfg_data,
    output rpc_pkg::cfg_t                      cfg
);

    rpc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.payload_offset       <= '0;
            cfg_reg.payload_length       <= 24'd1;
            cfg_reg.fill_value           <= '0;
            cfg_reg.check_sentinels      <= 1'b0;
            cfg_reg.pattern_seed         <= '0;
            cfg_reg.pattern_multiplier   <= 8'd1;
            cfg_reg.pattern_quarter_step <= '0;
            cfg_reg.crc_expected         <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (rpc_pkg::cfg_index_t'(cfg_index))
                rpc_pkg::REG_PAYLOAD_OFFSET:
                    cfg_reg.payload_offset <= cfg_data[rpc_pkg::OFFSET_W-1:0];
                rpc_pkg::REG_PAYLOAD_LENGTH:
                    cfg_reg.payload_length <= cfg_data[rpc_pkg::LENGTH_W-1:0];
                rpc_pkg::REG_FILL_VALUE:
                    cfg_reg.fill_value <= cfg_data[7:0];
                rpc_pkg::REG_CHECK_SENTINELS:
                    cfg_reg.check_sentinels <= cfg_data[0];
                rpc_pkg::REG_PATTERN_SEED:
                    cfg_reg.pattern_seed <= cfg_data[7:0];
                rpc_pkg::REG_PATTERN_MULTIPLIER:
                    cfg_reg.pattern_multiplier <= cfg_data[7:0];
                rpc_pkg::REG_PATTERN_QUARTER_STEP:
                    cfg_reg.pattern_quarter_step <= cfg_data[7:0];
                rpc_pkg::REG_CRC_EXPECTED:
                    cfg_reg.crc_expected <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/core/rpc_scan.sv */
`default_nettype none

module rpc_scan (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire rpc_pkg::cfg_t             cfg,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [7:0]                data_byte,
    input  wire logic                      last,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           pattern_match,
    output logic                           fill_intact,
    output logic [rpc_pkg::CRC_W-1:0]      checksum,
    output logic                           checksum_match,
    output logic                           region_too_short
);

    logic                        s_valid_reg;
    logic [7:0]                  s_byte_reg;
    logic                        s_last_reg;

    logic [rpc_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [rpc_pkg::CRC_W-1:0]   crc_reg, crc_next;
    logic [7:0]                  pattern_reg, pattern_next;
    logic                        payload_ok_reg, payload_ok_next;
    logic                        sentinel_ok_reg, sentinel_ok_next;

    logic                        out_valid_reg;
    logic                        pattern_match_reg;
    logic                        fill_intact_reg;
    logic [rpc_pkg::CRC_W-1:0]   checksum_reg;
    logic                        checksum_match_reg;
    logic                        region_too_short_reg;

    logic                        out_free;
    logic                        s_advance;
    logic                        in_fire;
    logic [rpc_pkg::END_W-1:0]   region_end;
    logic                        in_range;
    logic                        in_window;
    logic                        first_idx;
    logic [1:0]                  idx_low;
    logic [7:0]                  expect_byte;
    logic [7:0]                  quarter_add;
    logic                        too_short;
    logic [rpc_pkg::CRC_W-1:0]   crc_final;

    assign out_free  = !out_valid_reg || out_ready;
    assign s_advance = s_valid_reg && (!s_last_reg || out_free);
    assign in_ready  = !s_valid_reg || s_advance;
    assign in_fire   = in_valid && in_ready;

    assign region_end = {2'b00, cfg.payload_offset} + {1'b0, cfg.payload_length};
    assign in_range   = pos_reg < rpc_pkg::MAX_REGION_BYTES;
    assign in_window  = ({1'b0, pos_reg} >= {2'b00, cfg.payload_offset})
                        && ({1'b0, pos_reg} < region_end);
    assign first_idx  = pos_reg == {1'b0, cfg.payload_offset};
    assign idx_low    = pos_reg[1:0] - cfg.payload_offset[1:0];

    always_comb
    begin
        expect_byte      = first_idx ? cfg.pattern_seed : pattern_reg;
        quarter_add      = (idx_low == 2'd3) ? cfg.pattern_quarter_step : 8'd0;
        pos_next         = pos_reg;
        crc_next         = crc_reg;
        pattern_next     = pattern_reg;
        payload_ok_next  = payload_ok_reg;
        sentinel_ok_next = sentinel_ok_reg;
        if (in_range)
        begin
            if (in_window)
            begin
                if (s_byte_reg != expect_byte)
                begin
                    payload_ok_next = 1'b0;
                end
                crc_next     = rpc_pkg::crc32c_byte(crc_reg, s_byte_reg);
                pattern_next = expect_byte + cfg.pattern_multiplier + quarter_add;
            end
            else if (cfg.check_sentinels && (s_byte_reg != cfg.fill_value))
            begin
                sentinel_ok_next = 1'b0;
            end
            pos_next = pos_reg + 1'b1;
        end
        too_short = {1'b0, pos_next} < region_end;
        crc_final = ~crc_next;
    end

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s_byte_reg <= data_byte;
            s_last_reg <= last;
        end
    end

    // region state; restart after the last word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            crc_reg         <= rpc_pkg::CRC_INIT;
            payload_ok_reg  <= 1'b1;
            sentinel_ok_reg <= 1'b1;
        end
        else if (s_advance)
        begin
            if (s_last_reg)
            begin
                pos_reg         <= '0;
                crc_reg         <= rpc_pkg::CRC_INIT;
                payload_ok_reg  <= 1'b1;
                sentinel_ok_reg <= 1'b1;
            end
            else
            begin
                pos_reg         <= pos_next;
                crc_reg         <= crc_next;
                payload_ok_reg  <= payload_ok_next;
                sentinel_ok_reg <= sentinel_ok_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
        end
        else if (s_advance)
        begin
            if (s_last_reg)
            begin
                pattern_reg <= cfg.pattern_seed;
            end
            else
            begin
                pattern_reg <= pattern_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s_advance && s_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_advance && s_last_reg)
        begin
            region_too_short_reg <= too_short;
            if (too_short)
            begin
                pattern_match_reg    <= 1'b0;
                fill_intact_reg      <= 1'b0;
                checksum_reg         <= '0;
                checksum_match_reg   <= 1'b0;
            end
            else
            begin
                pattern_match_reg    <= payload_ok_next;
                fill_intact_reg      <= !cfg.check_sentinels || sentinel_ok_next;
                checksum_reg         <= crc_final;
                checksum_match_reg   <= crc_final == cfg.crc_expected;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign pattern_match    = pattern_match_reg;
    assign fill_intact      = fill_intact_reg;
    assign checksum         = checksum_reg;
    assign checksum_match   = checksum_match_reg;
    assign region_too_short = region_too_short_reg;

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= rpc_pkg::MAX_REGION_BYTES)
        else $error("byte position past saturation");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        s_advance && s_last_reg |=> pos_reg == '0 && crc_reg == rpc_pkg::CRC_INIT
        && payload_ok_reg && sentinel_ok_reg)
        else $error("region state not restarted after last word");

    a_short_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && region_too_short_reg |-> !pattern_match_reg
        && !fill_intact_reg && !checksum_match_reg && checksum_reg == '0)
        else $error("short region result carries set flags");

    a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg && s_last_reg && !out_free |=> s_valid_reg && $stable(pos_reg))
        else $error("stalled last word lost");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        s_advance && s_last_reg |-> out_free)
        else $error("result overwritten before taken");

endmodule

`default_nettype wire

/* rtl/core/region_pattern_crc_checker.sv */
// A byte is taken into the input register and checked from there; the result of a last
// byte is loaded into the result register, where it is held until it is taken.
// Throughput: one byte per cycle while results are taken; a last byte waits in the input
// register while the previous result is still held. CRC-32C step and pattern compare
// sit in the single stage between the input register and the result register.
// Reset (rst_n, async, active low): configuration to defaults, region state restarted.
`default_nettype none

module region_pattern_crc_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [rpc_pkg::INDEX_W-1:0] cfg_index,
    input  wire logic [rpc_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [7:0]                data_byte,
    input  wire logic                      last,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           pattern_match,
    output logic                           fill_intact,
    output logic [rpc_pkg::CRC_W-1:0]      checksum,
    output logic                           checksum_match,
    output logic                           region_too_short
);

    rpc_pkg::cfg_t cfg;

    rpc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rpc_scan u_scan (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .last             (last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .pattern_match    (pattern_match),
        .fill_intact      (fill_intact),
        .checksum         (checksum),
        .checksum_match   (checksum_match),
        .region_too_short (region_too_short)
    );

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned CYCLE_LIMIT = 150000;
    localparam int unsigned SHOWN_MISMATCHES = 10;

    typedef struct packed {
        logic        pattern_match;
        logic        fill_intact;
        logic [31:0] checksum;
        logic        checksum_match;
        logic        region_too_short;
    } region_verdict_t;

    typedef struct {
        rpc_pkg::cfg_t   setting;
        bit              load_crc;
        int unsigned     span;
        int              err_at;
        logic [7:0]      err_mask;
        bit              fixed;
        region_verdict_t want;
    } probe_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [rpc_pkg::INDEX_W-1:0] cfg_index = '0;
    logic [rpc_pkg::CFG_W-1:0]   cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [7:0]        data_byte = 8'd0;
    logic              last = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              pattern_match;
    logic              fill_intact;
    logic [rpc_pkg::CRC_W-1:0]   checksum;
    logic              checksum_match;
    logic              region_too_short;

    rpc_pkg::cfg_t     live_cfg;
    logic [23:0]       seen_bytes;
    logic [31:0]       crc_acc;
    logic [7:0]        next_pattern;
    logic              pattern_good;
    logic              fill_good;
    region_verdict_t   verdict_q[$];
    bit                fixed_verdict_armed = 1'b0;
    region_verdict_t   fixed_verdict;

    int unsigned       send_idle = 0;
    int unsigned       recv_idle = 0;
    int unsigned       cycle_count = 0;
    int unsigned       mismatches = 0;
    int unsigned       verdicts_seen = 0;
    int unsigned       bytes_sent = 0;
    int unsigned       regions_sent = 0;
    int unsigned       settings_applied = 0;

    probe_row_t        probe_rows[9];

    region_pattern_crc_checker dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .last             (last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .pattern_match    (pattern_match),
        .fill_intact      (fill_intact),
        .checksum         (checksum),
        .checksum_match   (checksum_match),
        .region_too_short (region_too_short)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ rpc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic rpc_pkg::cfg_t make_cfg(input int unsigned off, len, pre, chk, seed,
                                               mult, qs, input logic [31:0] crc);
        rpc_pkg::cfg_t c;
        c.payload_offset       = 23'(off);
        c.payload_length       = 24'(len);
        c.fill_value           = 8'(pre);
        c.check_sentinels      = 1'(chk);
        c.pattern_seed         = 8'(seed);
        c.pattern_multiplier   = 8'(mult);
        c.pattern_quarter_step = 8'(qs);
        c.crc_expected         = crc;
        return c;
    endfunction

    function automatic logic [7:0] clean_byte(input rpc_pkg::cfg_t c, input int unsigned p);
        int unsigned off;
        int unsigned idx;
        int unsigned v;
        off = c.payload_offset;
        if (p >= off && p < off + c.payload_length)
        begin
            idx = p - off;
            v = c.pattern_seed + c.pattern_multiplier * idx
                + c.pattern_quarter_step * (idx / 4);
            return 8'(v);
        end
        return c.fill_value;
    endfunction

    function automatic logic [31:0] region_crc(input rpc_pkg::cfg_t c);
        logic [31:0] acc;
        acc = '1;
        for (int unsigned i = 0; i < c.payload_length; i++)
        begin
            acc = crc_step(acc, clean_byte(c, c.payload_offset + i));
        end
        return ~acc;
    endfunction

    function automatic rpc_pkg::cfg_t random_setting(input int ph, input int slot);
        rpc_pkg::cfg_t c;
        c = make_cfg($urandom_range(0, 6),
                     ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12),
                     $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255), 32'd0);
        if (slot == 3)
        begin
            case (ph)
                0: c.payload_offset = 23'h7fffff;
                1:
                begin
                    c.payload_offset = 23'd0;
                    c.payload_length = 24'h800000;
                end
                default:
                begin
                    c.payload_offset  = 23'd0;
                    c.payload_length  = 24'd0;
                    c.check_sentinels = 1'b1;
                end
            endcase
        end
        if (c.payload_length <= 64 && $urandom_range(0, 1) == 1)
            c.crc_expected = region_crc(c);
        else
            c.crc_expected = $urandom;
        return c;
    endfunction

    task automatic restart_region();
        seen_bytes   = '0;
        crc_acc      = rpc_pkg::CRC_INIT;
        next_pattern = live_cfg.pattern_seed;
        pattern_good = 1'b1;
        fill_good    = 1'b1;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic fin);
        logic [24:0]     win_start;
        logic [24:0]     win_end;
        logic [24:0]     pos;
        logic [23:0]     idx;
        logic [7:0]      want;
        region_verdict_t v;
        win_start = {2'b00, live_cfg.payload_offset};
        win_end   = win_start + {1'b0, live_cfg.payload_length};
        pos       = {1'b0, seen_bytes};
        if (seen_bytes < rpc_pkg::MAX_REGION_BYTES)
        begin
            if (pos >= win_start && pos < win_end)
            begin
                idx  = 24'(pos - win_start);
                want = (idx == 24'd0) ? live_cfg.pattern_seed : next_pattern;
                if (b != want)
                    pattern_good = 1'b0;
                crc_acc = crc_step(crc_acc, b);
                want = want + live_cfg.pattern_multiplier;
                if (idx[1:0] == 2'd3)
                    want = want + live_cfg.pattern_quarter_step;
                next_pattern = want;
            end
            else if (live_cfg.check_sentinels && b != live_cfg.fill_value)
            begin
                fill_good = 1'b0;
            end
            seen_bytes = seen_bytes + 24'd1;
        end
        if (fin)
        begin
            if ({1'b0, seen_bytes} < win_end)
            begin
                v = '{1'b0, 1'b0, 32'd0, 1'b0, 1'b1};
            end
            else
            begin
                v.pattern_match    = pattern_good;
                v.fill_intact      = !live_cfg.check_sentinels || fill_good;
                v.checksum         = ~crc_acc;
                v.checksum_match   = (~crc_acc == live_cfg.crc_expected);
                v.region_too_short = 1'b0;
            end
            verdict_q.insert(verdict_q.size(), fixed_verdict_armed ? fixed_verdict : v);
            restart_region();
        end
    endtask

    task automatic write_reg(input rpc_pkg::cfg_index_t idx, input logic [31:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic apply_setting(input rpc_pkg::cfg_t c);
        live_cfg = c;
        write_reg(rpc_pkg::REG_PAYLOAD_OFFSET, 32'(c.payload_offset));
        write_reg(rpc_pkg::REG_PAYLOAD_LENGTH, 32'(c.payload_length));
        write_reg(rpc_pkg::REG_FILL_VALUE, 32'(c.fill_value));
        write_reg(rpc_pkg::REG_CHECK_SENTINELS, 32'(c.check_sentinels));
        write_reg(rpc_pkg::REG_PATTERN_SEED, 32'(c.pattern_seed));
        write_reg(rpc_pkg::REG_PATTERN_MULTIPLIER, 32'(c.pattern_multiplier));
        write_reg(rpc_pkg::REG_PATTERN_QUARTER_STEP, 32'(c.pattern_quarter_step));
        write_reg(rpc_pkg::REG_CRC_EXPECTED, c.crc_expected);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings_applied++;
    endtask

    // hold each word until taken; idle only between words
    task automatic push_word(input logic [7:0] b, input logic fin);
        if ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last      <= fin;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_region(input rpc_pkg::cfg_t c, input int unsigned span,
                               input int err_at, input logic [7:0] mask, input bit noise);
        logic [7:0] b;
        for (int unsigned p = 0; p < span; p++)
        begin
            b = noise ? 8'($urandom) : clean_byte(c, p);
            if (int'(p) == err_at)
                b = b ^ mask;
            push_word(b, p == span - 1);
        end
        bytes_sent += span;
        regions_sent++;
    endtask

    task automatic wait_drain(input int unsigned tail);
        in_valid <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            absorb_byte(data_byte, last);
    end

    always @(posedge clk)
    begin
        region_verdict_t exp_v;
        if (rst_n && out_valid && out_ready)
        begin
            verdicts_seen++;
            if (verdict_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("[%0t] unexpected verdict: %b %b %h %b %b", $time,
                             pattern_match, fill_intact, checksum, checksum_match,
                             region_too_short);
            end
            else
            begin
                exp_v = verdict_q.pop_front();
                if (pattern_match !== exp_v.pattern_match
                    || fill_intact !== exp_v.fill_intact
                    || checksum !== exp_v.checksum
                    || checksum_match !== exp_v.checksum_match
                    || region_too_short !== exp_v.region_too_short)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCHES)
                        $display({"[%0t] verdict mismatch: exp %b %b %h %b %b,",
                                  " got %b %b %h %b %b"},
                                 $time, exp_v.pattern_match, exp_v.fill_intact,
                                 exp_v.checksum, exp_v.checksum_match, exp_v.region_too_short,
                                 pattern_match, fill_intact, checksum, checksum_match,
                                 region_too_short);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
                     verdict_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rpc_pkg::cfg_t c;
        int unsigned span;
        int unsigned wend;
        int unsigned sent;
        int unsigned budget;
        int          err_at;
        int          kind;
        logic [7:0]  mask;
        bit          noise;

        live_cfg = make_cfg(0, 1, 0, 0, 0, 1, 0, 32'd0);
        restart_region();

        probe_rows[0] = '{make_cfg(0, 1, 0, 0, 0, 1, 0, 32'd0), 1'b0, 1, -1, 8'h00,
                          1'b0, '0};
        probe_rows[1] = '{make_cfg(3, 1, 0, 0, 0, 1, 0, 32'd0), 1'b0, 2, -1, 8'h00,
                          1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, 1'b1}};
        probe_rows[2] = '{make_cfg(0, 0, 'hff, 1, 0, 1, 0, 32'd0), 1'b0, 2, -1, 8'h00,
                          1'b1, '{1'b1, 1'b1, 32'd0, 1'b1, 1'b0}};
        probe_rows[3] = '{make_cfg(2, 5, 'ha5, 1, 'hff, 'hff, 'hff, 32'd0), 1'b0, 8, -1, 8'h00,
                          1'b0, '0};
        probe_rows[4] = '{make_cfg(1, 2, 'h5a, 1, 'h80, 'h01, 'h00, 32'd0), 1'b0, 4, 0, 8'h80,
                          1'b0, '0};
        probe_rows[5] = '{make_cfg(1, 1, 'h5a, 0, 'h80, 'h01, 'h00, 32'd0), 1'b0, 2, 0, 8'hff,
                          1'b0, '0};
        probe_rows[6] = '{make_cfg(0, 3, 'h00, 1, 'h00, 'h00, 'h00, 32'd0), 1'b0, 3, 1, 8'h01,
                          1'b0, '0};
        probe_rows[7] = '{make_cfg(8388607, 8388608, 'hff, 1, 'hff, 'hff, 'hff, 32'hffffffff),
                          1'b0, 1, -1, 8'h00, 1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, 1'b1}};
        probe_rows[8] = '{make_cfg(0, 2, 'h00, 1, 'h5a, 'h37, 'h10, 32'd0), 1'b1, 2, -1, 8'h00,
                          1'b0, '0};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 22;
        recv_idle = 80;
        foreach (probe_rows[i])
        begin
            c = probe_rows[i].setting;
            if (probe_rows[i].load_crc)
                c.crc_expected = region_crc(c);
            apply_setting(c);
            fixed_verdict_armed = probe_rows[i].fixed;
            fixed_verdict       = probe_rows[i].want;
            send_region(c, probe_rows[i].span, probe_rows[i].err_at, probe_rows[i].err_mask,
                        1'b0);
            wait_drain(4);
            fixed_verdict_armed = 1'b0;
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 22 : (ph == 1) ? 80 : 0;
            recv_idle = (ph == 0) ? 80 : (ph == 1) ? 22 : 0;
            for (int slot = 0; slot < 4; slot++)
            begin
                c = random_setting(ph, slot);
                apply_setting(c);
                budget = (slot == 3 && ph < 2) ? 20 : 60;
                sent = 0;
                while (sent < budget)
                begin
                    wend   = c.payload_offset + c.payload_length;
                    kind   = $urandom_range(0, 99);
                    err_at = -1;
                    mask   = 8'h00;
                    noise  = 1'b0;
                    if (wend > 64)
                    begin
                        span = $urandom_range(1, 6);
                    end
                    else
                    begin
                        span = wend + $urandom_range(0, 3);
                        if (span == 0)
                            span = 1;
                        if (kind >= 90)
                        begin
                            noise = 1'b1;
                            span  = $urandom_range(1, wend + 4);
                        end
                        else if (kind >= 80 && wend > 1)
                        begin
                            span = $urandom_range(1, wend - 1);
                        end
                        else if (kind >= 65)
                        begin
                            err_at = $urandom_range(0, span - 1);
                            mask   = 8'($urandom_range(1, 255));
                        end
                    end
                    send_region(c, span, err_at, mask, noise);
                    sent += span;
                end
                wait_drain(4);
            end
        end

        wait_drain(10);
        $display("Streamed %0d regions (%0d bytes) across %0d register settings",
                 regions_sent, bytes_sent, settings_applied);
        $display("and three pacing modes; compared %0d verdicts, %0d mismatches.",
                 verdicts_seen, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/rpc_pkg.sv
rtl/core/rpc_cfg_regs.sv
rtl/core/rpc_scan.sv
rtl/core/region_pattern_crc_checker.sv
dv/testbench.sv
